// ----- hdl/sfd_pkg.sv -----
// Shared types and constants of the serial frame deframer.
// No dependencies; the parser, the top level and the testbench import this package.
package sfd_pkg;

  // frame format
  localparam logic [7:0] SYNC_BYTE   = 8'hFA;
  localparam logic [7:0] ADDR_BYTE   = 8'hFF;
  localparam int         STORE_DEPTH = 256;
  localparam int         STORE_AW    = 8;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_READ    = 2'd2,
    OP_NOP     = 2'd3
  } sfd_op_e;

  // command from the top level to the parser
  typedef struct packed {
    logic       valid;
    logic       clear;
    logic [7:0] rx_byte;
  } sfd_cmd_t;

  // parser completion status
  typedef struct packed {
    logic       done;
    logic       ready;
    logic       rejected;
    logic [7:0] msg_id;
    logic [7:0] len;
  } sfd_res_t;

  // write port into the frame store
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } sfd_store_wr_t;

endpackage

// ----- hdl/sfd_intf.sv -----
// Handshake channels of the serial frame deframer: input and result.
// No dependencies.
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, output opcode, output rx_byte, output read_index,
                  input ready);
  modport sink   (input valid, input opcode, input rx_byte, input read_index,
                  output ready);
endinterface

interface sfd_out_if;
  logic       valid;
  logic       ready;
  logic       frame_ready;
  logic       frame_rejected;
  logic [7:0] msg_id;
  logic [7:0] payload_len;
  logic [7:0] read_data;

  modport source (output valid, output frame_ready, output frame_rejected,
                  output msg_id, output payload_len, output read_data, input ready);
  modport sink   (input valid, input frame_ready, input frame_rejected,
                  input msg_id, input payload_len, input read_data, output ready);
endinterface

// ----- hdl/sfd_parser.sv -----
// Receive buffer and frame parser: circular byte memory with a sequencer
// that checks header, length and checksum, copies payloads and resyncs.
// Depends on sfd_pkg.
module sfd_parser #(
  parameter int MAX_PAYLOAD  = 254,
  parameter int BUFFER_DEPTH = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sfd_pkg::sfd_cmd_t     cmd_i,
  output sfd_pkg::sfd_res_t     res_o,
  output sfd_pkg::sfd_store_wr_t store_wr_o
);
  import sfd_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(BUFFER_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
  localparam logic [7:0]    MAX_LEN = 8'(MAX_PAYLOAD);

  typedef enum logic [9:0] {
    P_IDLE = 10'b00_0000_0001,
    P_CHECK = 10'b00_0000_0010,
    P_HDR0 = 10'b00_0000_0100,
    P_HDR1 = 10'b00_0000_1000,
    P_HDR3 = 10'b00_0001_0000,
    P_SUM  = 10'b00_0010_0000,
    P_COPY = 10'b00_0100_0000,
    P_REJ  = 10'b00_1000_0000,
    P_SCAN = 10'b01_0000_0000,
    P_DONE = 10'b10_0000_0000
  } prs_state_e;

  prs_state_e    state_q, state_d;
  logic [CW-1:0] held_q, held_d;
  logic [AW-1:0] start_q, start_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [7:0]    len_q, len_d;
  logic [7:0]    id_q, id_d;
  logic [7:0]    sum_q, sum_d;
  logic          ready_q, ready_d;
  logic          rej_q, rej_d;

  logic [7:0]    buf_mem [BUFFER_DEPTH];
  logic [7:0]    buf_rdata_q;
  logic          buf_we;
  logic [AW-1:0] buf_waddr;
  logic [AW-1:0] rd_off;
  logic [AW-1:0] buf_raddr;
  logic [CW-1:0] wr_held;
  logic [AW-1:0] wr_start;
  logic [7:0]    sum_next;

  // circular address: base plus offset, one wrap at most
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  // receive buffer memory, registered read
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= cmd_i.rx_byte;
    end
    buf_rdata_q <= buf_mem[buf_raddr];
  end

  assign buf_raddr = wrap_add(start_q, rd_off);
  assign sum_next  = sum_q + buf_rdata_q;

  // a full buffer drops its bytes before the new one goes in
  assign wr_held  = (held_q >= DEPTH_C) ? '0 : held_q;
  assign wr_start = (held_q >= DEPTH_C) ? '0 : start_q;
  assign buf_waddr = wrap_add(wr_start, wr_held[AW-1:0]);

  // parse sequencer
  always_comb begin
    state_d  = state_q;
    held_d   = held_q;
    start_d  = start_q;
    idx_d    = idx_q;
    len_d    = len_q;
    id_d     = id_q;
    sum_d    = sum_q;
    ready_d  = ready_q;
    rej_d    = rej_q;
    rd_off   = '0;
    buf_we   = 1'b0;
    store_wr_o.we   = 1'b0;
    store_wr_o.addr = STORE_AW'(idx_q - AW'(4));
    store_wr_o.data = buf_rdata_q;

    case (state_q)
      P_IDLE: begin
        if (cmd_i.valid) begin
          ready_d = 1'b0;
          rej_d   = 1'b0;
          if (cmd_i.clear) begin
            held_d  = '0;
            start_d = '0;
            state_d = P_DONE;
          end else begin
            buf_we  = 1'b1;
            start_d = wr_start;
            held_d  = wr_held + CW'(1);
            state_d = P_CHECK;
          end
        end
      end
      P_CHECK: begin
        rd_off = '0;
        if (held_q < CW'(4)) begin
          state_d = P_DONE;
        end else begin
          state_d = P_HDR0;
        end
      end
      P_HDR0: begin
        rd_off = AW'(1);
        if (buf_rdata_q != SYNC_BYTE) begin
          state_d = P_REJ;
        end else begin
          state_d = P_HDR1;
        end
      end
      P_HDR1: begin
        rd_off = AW'(3);
        if (buf_rdata_q != ADDR_BYTE) begin
          state_d = P_REJ;
        end else begin
          state_d = P_HDR3;
        end
      end
      P_HDR3: begin
        rd_off = AW'(1);
        if (buf_rdata_q > MAX_LEN) begin
          state_d = P_REJ;
        end else if (held_q < CW'(buf_rdata_q) + CW'(5)) begin
          state_d = P_DONE;
        end else begin
          len_d   = buf_rdata_q;
          idx_d   = AW'(1);
          sum_d   = '0;
          state_d = P_SUM;
        end
      end
      // sum from the address byte through the checksum must come to zero
      P_SUM: begin
        sum_d = sum_next;
        if (idx_q == AW'(2)) begin
          id_d = buf_rdata_q;
        end
        if (idx_q == AW'(len_q) + AW'(4)) begin
          if (sum_next != 8'd0) begin
            state_d = P_REJ;
          end else if (len_q == 8'd0) begin
            ready_d = 1'b1;
            held_d  = '0;
            start_d = '0;
            state_d = P_DONE;
          end else begin
            rd_off  = AW'(4);
            idx_d   = AW'(4);
            state_d = P_COPY;
          end
        end else begin
          rd_off = idx_q + AW'(1);
          idx_d  = idx_q + AW'(1);
        end
      end
      // payload copy into the frame store, one byte a cycle
      P_COPY: begin
        store_wr_o.we = 1'b1;
        if (idx_q == AW'(len_q) + AW'(3)) begin
          ready_d = 1'b1;
          held_d  = '0;
          start_d = '0;
          state_d = P_DONE;
        end else begin
          rd_off = idx_q + AW'(1);
          idx_d  = idx_q + AW'(1);
        end
      end
      P_REJ: begin
        rej_d   = 1'b1;
        rd_off  = AW'(1);
        idx_d   = AW'(1);
        state_d = P_SCAN;
      end
      // look for the next sync byte after the first held byte
      P_SCAN: begin
        if (buf_rdata_q == SYNC_BYTE) begin
          start_d = wrap_add(start_q, idx_q);
          held_d  = held_q - CW'(idx_q);
          state_d = P_CHECK;
        end else if (CW'(idx_q) + CW'(1) == held_q) begin
          held_d  = '0;
          start_d = '0;
          state_d = P_CHECK;
        end else begin
          rd_off = idx_q + AW'(1);
          idx_d  = idx_q + AW'(1);
        end
      end
      P_DONE: begin
        state_d = P_IDLE;
      end
      default: begin
        state_d = P_IDLE;
      end
    endcase
  end

  assign res_o.done     = (state_q == P_DONE);
  assign res_o.ready    = ready_q;
  assign res_o.rejected = rej_q;
  assign res_o.msg_id   = id_q;
  assign res_o.len      = len_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
      held_q  <= '0;
      start_q <= '0;
      ready_q <= 1'b0;
      rej_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      start_q <= start_d;
      ready_q <= ready_d;
      rej_q   <= rej_d;
    end
  end

  // scan working registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    len_q <= len_d;
    id_q  <= id_d;
    sum_q <= sum_d;
  end

  // fill level stays within the buffer
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= DEPTH_C)
    else $error("held count beyond buffer depth");

  // completion is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done |=> !res_o.done)
    else $error("parser done held for more than one cycle");

  // a good frame leaves the buffer empty
  a_good_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.done && res_o.ready) |-> (held_q == '0 && start_q == '0))
    else $error("buffer not emptied after good frame");

  // payload copy only for legal non-empty lengths
  a_copy_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == P_COPY) |-> (len_q != 8'd0 && len_q <= MAX_LEN))
    else $error("payload copy with illegal length");

endmodule

// ----- hdl/serial_frame_deframer_core.sv -----
// Top level of the serial frame deframer: handshake, result register,
// frame store and read path. Depends on sfd_pkg, sfd_intf and sfd_parser.
//
// One transaction at a time. A received byte that completes a frame makes
// the parser walk the receive buffer through its single read port, once for
// the checksum and once for the copy into the frame store. Each rejection
// adds one buffer pass of up to the held byte count while searching for the
// next 0xFA. The next transaction is taken as soon as the previous result
// sits in the output register.
module serial_frame_deframer_core #(
  parameter int MAX_PAYLOAD  = 254,
  parameter int BUFFER_DEPTH = 512
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfd_in_if.sink       in_i,
  sfd_out_if.source    out_o
);
  import sfd_pkg::*;

  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  typedef enum logic [3:0] {
    T_IDLE   = 4'b0001,
    T_READ   = 4'b0010,
    T_PARSE  = 4'b0100,
    T_RESULT = 4'b1000
  } top_state_e;

  top_state_e    state_q, state_d;
  logic [7:0]    last_id_q, last_id_d;
  logic [7:0]    last_len_q, last_len_d;
  logic          rs_ready_q, rs_ready_d;
  logic          rs_rej_q, rs_rej_d;
  logic [7:0]    rs_data_q, rs_data_d;
  logic [7:0]    rd_idx_q, rd_idx_d;
  logic          out_valid_q, out_valid_d;
  logic          out_load;
  logic          out_ready_q, out_rej_q;
  logic [7:0]    out_id_q, out_len_q, out_data_q;
  logic          in_fire;
  sfd_op_e       op;
  sfd_cmd_t      cmd;
  sfd_res_t      prs_res;
  sfd_store_wr_t store_wr;

  logic [7:0]    store_mem [STORE_DEPTH];
  logic [7:0]    store_rdata_q;

  sfd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .res_o     (prs_res),
    .store_wr_o(store_wr)
  );

  // frame store: payload of the last good frame
  always_ff @(posedge clk_i) begin
    if (store_wr.we) begin
      store_mem[store_wr.addr] <= store_wr.data;
    end
    store_rdata_q <= store_mem[in_i.read_index];
  end

  assign in_i.ready = (state_q == T_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign op         = sfd_op_e'(in_i.opcode);
  assign out_load   = (state_q == T_RESULT) && (!out_valid_q || out_o.ready);

  // transaction sequencing
  always_comb begin
    state_d     = state_q;
    last_id_d   = last_id_q;
    last_len_d  = last_len_q;
    rs_ready_d  = rs_ready_q;
    rs_rej_d    = rs_rej_q;
    rs_data_d   = rs_data_q;
    rd_idx_d    = rd_idx_q;
    cmd.valid   = 1'b0;
    cmd.clear   = (op == OP_TIMEOUT);
    cmd.rx_byte = in_i.rx_byte;

    case (state_q)
      T_IDLE: begin
        if (in_fire) begin
          rs_ready_d = 1'b0;
          rs_rej_d   = 1'b0;
          rs_data_d  = '0;
          rd_idx_d   = in_i.read_index;
          case (op)
            OP_BYTE, OP_TIMEOUT: begin
              cmd.valid = 1'b1;
              state_d   = T_PARSE;
            end
            OP_READ: begin
              state_d = T_READ;
            end
            default: begin
              state_d = T_RESULT;
            end
          endcase
        end
      end
      // bytes past the stored payload read as zero
      T_READ: begin
        rs_data_d = (rd_idx_q < last_len_q) ? store_rdata_q : 8'd0;
        state_d   = T_RESULT;
      end
      T_PARSE: begin
        if (prs_res.done) begin
          rs_ready_d = prs_res.ready;
          rs_rej_d   = prs_res.rejected;
          if (prs_res.ready) begin
            last_id_d  = prs_res.msg_id;
            last_len_d = prs_res.len;
          end
          state_d = T_RESULT;
        end
      end
      T_RESULT: begin
        if (out_load) begin
          state_d = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      last_id_q   <= '0;
      last_len_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_id_q   <= last_id_d;
      last_len_q  <= last_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // staged result and output payload
  always_ff @(posedge clk_i) begin
    rs_ready_q <= rs_ready_d;
    rs_rej_q   <= rs_rej_d;
    rs_data_q  <= rs_data_d;
    rd_idx_q   <= rd_idx_d;
    if (out_load) begin
      out_ready_q <= rs_ready_q;
      out_rej_q   <= rs_rej_q;
      out_id_q    <= last_id_q;
      out_len_q   <= last_len_q;
      out_data_q  <= rs_data_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.frame_ready    = out_ready_q;
  assign out_o.frame_rejected = out_rej_q;
  assign out_o.msg_id         = out_id_q;
  assign out_o.payload_len    = out_len_q;
  assign out_o.read_data      = out_data_q;

  // parser completes only while a byte or timeout transaction is open
  a_done_in_parse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prs_res.done |-> (state_q == T_PARSE))
    else $error("parser completion outside a parse transaction");

  // a new result enters only from the result stage
  a_out_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> ($past(state_q) == T_RESULT))
    else $error("result register loaded out of sequence");

  // reported length never exceeds the payload limit
  a_len_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.payload_len <= MAX_LEN))
    else $error("reported payload length beyond limit");

  // frame store is not written while a read transaction uses it
  a_store_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_wr.we |-> (state_q == T_PARSE))
    else $error("frame store written outside a parse transaction");

endmodule

// ----- tb/sv/serial_frame_deframer_core_tb.sv -----
// Self-checking testbench of serial_frame_deframer_core: directed rows, then random
// frame sequences, checked against a cycle-free model of the deframer.
// Depends on sfd_pkg, sfd_intf and the deframer RTL.
module serial_frame_deframer_core_tb;
  import sfd_pkg::*;

  localparam int MAX_LEN      = 254;
  localparam int DEPTH        = 512;
  localparam int ITEM_TARGET  = 850;
  localparam int CALM_ITEMS   = 120;
  localparam int IDLE_LIMIT   = 300000;
  localparam int DRAIN_CYCLES = 600;

  typedef struct packed {
    logic       frame_ready;
    logic       frame_rejected;
    logic [7:0] msg_id;
    logic [7:0] payload_len;
    logic [7:0] read_data;
  } frame_status_t;

  typedef struct {
    sfd_op_e       op;
    logic [7:0]    rx_byte;
    logic [7:0]    index;
    bit            known;
    frame_status_t want;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();

  serial_frame_deframer_core #(
    .MAX_PAYLOAD  (MAX_LEN),
    .BUFFER_DEPTH (DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // deframer model state
  logic [7:0]  hold_mem [DEPTH];
  int unsigned hold_head  = 0;
  int unsigned hold_count = 0;
  logic [7:0]  payload_mem [256];
  logic [7:0]  good_id  = 8'h00;
  logic [7:0]  good_len = 8'h00;

  frame_status_t status_due_q [$];
  stim_row_t     dir_rows [$];
  logic [7:0]    body_q [$];
  logic [7:0]    burst_q [$];

  int fail_cnt    = 0;
  int items_sent  = 0;
  int idle_cycles = 0;
  bit calm        = 1'b0;

  function automatic logic [7:0] held_byte(int unsigned k);
    return hold_mem[(hold_head + k) % DEPTH];
  endfunction

  // drop bytes up to the next sync byte after the first, or everything
  function automatic void skip_to_next_sync();
    int unsigned i;
    for (i = 1; i < hold_count; i++) begin
      if (held_byte(i) == SYNC_BYTE) begin
        hold_head  = (hold_head + i) % DEPTH;
        hold_count = hold_count - i;
        return;
      end
    end
    hold_count = 0;
    hold_head  = 0;
  endfunction

  // parse held bytes until more input is needed; returns {found, rejected}
  function automatic logic [1:0] scan_frames();
    logic        found;
    logic        rejected;
    int unsigned len;
    int unsigned k;
    logic [7:0]  sum;
    logic [7:0]  want_cs;
    found    = 1'b0;
    rejected = 1'b0;
    while (hold_count >= 4) begin
      if (held_byte(0) != SYNC_BYTE || held_byte(1) != ADDR_BYTE) begin
        rejected = 1'b1;
        skip_to_next_sync();
        continue;
      end
      len = held_byte(3);
      if (len > MAX_LEN) begin
        rejected = 1'b1;
        skip_to_next_sync();
        continue;
      end
      if (hold_count < len + 5) break;
      sum = 8'h00;
      for (k = 1; k < 4 + len; k++) sum = sum + held_byte(k);
      want_cs = 8'h00 - sum;
      if (want_cs != held_byte(4 + len)) begin
        rejected = 1'b1;
        skip_to_next_sync();
        continue;
      end
      good_id  = held_byte(2);
      good_len = 8'(len);
      for (k = 0; k < len; k++) payload_mem[k] = held_byte(4 + k);
      found      = 1'b1;
      hold_count = 0;
      hold_head  = 0;
      break;
    end
    return {found, rejected};
  endfunction

  // advance the model by one transaction and return its result
  function automatic frame_status_t predict_item(sfd_op_e op, logic [7:0] b, logic [7:0] idx);
    frame_status_t r;
    r = '0;
    case (op)
      OP_BYTE: begin
        if (hold_count >= DEPTH) begin
          hold_count = 0;
          hold_head  = 0;
        end
        hold_mem[(hold_head + hold_count) % DEPTH] = b;
        hold_count++;
        {r.frame_ready, r.frame_rejected} = scan_frames();
      end
      OP_TIMEOUT: begin
        hold_count = 0;
        hold_head  = 0;
      end
      OP_READ: begin
        if (idx < good_len) r.read_data = payload_mem[idx];
      end
      default: ;
    endcase
    r.msg_id      = good_id;
    r.payload_len = good_len;
    return r;
  endfunction

  function automatic void row(sfd_op_e op, logic [7:0] b, logic [7:0] idx, bit known,
                              frame_status_t want);
    stim_row_t s;
    s.op      = op;
    s.rx_byte = b;
    s.index   = idx;
    s.known   = known;
    s.want    = want;
    dir_rows.push_back(s);
  endfunction

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 7) == 0) return SYNC_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void fill_body(int n);
    body_q.delete();
    repeat (n) body_q.push_back(rand_byte());
  endfunction

  // append a frame around body_q to burst_q, optionally with a wrong checksum
  function automatic void emit_frame(logic [7:0] id, bit bad_cs);
    logic [7:0] sum;
    logic [7:0] cs;
    int i;
    sum = ADDR_BYTE + id + 8'(body_q.size());
    for (i = 0; i < body_q.size(); i++) sum = sum + body_q[i];
    cs = 8'h00 - sum + {7'd0, bad_cs};
    burst_q.push_back(SYNC_BYTE);
    burst_q.push_back(ADDR_BYTE);
    burst_q.push_back(id);
    burst_q.push_back(8'(body_q.size()));
    for (i = 0; i < body_q.size(); i++) burst_q.push_back(body_q[i]);
    burst_q.push_back(cs);
  endfunction

  // one input transaction; called at a falling edge, returns at a falling edge
  task automatic send_item(input sfd_op_e op, input logic [7:0] b, input logic [7:0] idx,
                           input bit known, input frame_status_t want);
    frame_status_t pred;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.rx_byte    <= b;
    in_ch.read_index <= idx;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    pred = predict_item(op, b, idx);
    status_due_q.push_back(known ? want : pred);
    if (op != OP_NOP) items_sent++;
    if (items_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_BYTE, b, 8'h00, 1'b0, '0);
  endtask

  task automatic send_burst();
    int i;
    for (i = 0; i < burst_q.size(); i++) send_byte(burst_q[i]);
    burst_q.delete();
  endtask

  // result side backpressure
  logic        out_ready_q = 1'b0;
  int unsigned hold_left   = 0;
  assign out_ch.ready = out_ready_q;

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
    end else if (!calm && out_ready_q && $urandom_range(0, 2) == 0) begin
      out_ready_q <= 1'b0;
      hold_left = $urandom_range(0, 13);
    end else begin
      out_ready_q <= 1'b1;
      hold_left = $urandom_range(0, 30);
    end
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    frame_status_t got;
    frame_status_t want;
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("serial_frame_deframer_core_tb: FAIL");
        $finish;
      end else if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = {out_ch.frame_ready, out_ch.frame_rejected, out_ch.msg_id,
               out_ch.payload_len, out_ch.read_data};
        if (status_due_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_cnt++;
        end else begin
          want = status_due_q.pop_front();
          if (got.frame_ready !== want.frame_ready) begin
            $error("frame_ready: expected %0d, got %0d", want.frame_ready, got.frame_ready);
            fail_cnt++;
          end
          if (got.frame_rejected !== want.frame_rejected) begin
            $error("frame_rejected: expected %0d, got %0d",
                   want.frame_rejected, got.frame_rejected);
            fail_cnt++;
          end
          if (got.msg_id !== want.msg_id) begin
            $error("msg_id: expected %0h, got %0h", want.msg_id, got.msg_id);
            fail_cnt++;
          end
          if (got.payload_len !== want.payload_len) begin
            $error("payload_len: expected %0d, got %0d", want.payload_len, got.payload_len);
            fail_cnt++;
          end
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
            fail_cnt++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    int pick;
    int n;
    int k;
    int frames_made;
    frames_made = 0;

    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_NOP;
    in_ch.rx_byte    = 8'h00;
    in_ch.read_index = 8'h00;

    // after reset, no-op, shortest frame
    row(OP_READ, 8'h00, 8'h00, 1'b1, {1'b0, 1'b0, 8'h00, 8'h00, 8'h00});
    row(OP_NOP,  8'hFF, 8'hFF, 1'b1, {1'b0, 1'b0, 8'h00, 8'h00, 8'h00});
    row(OP_BYTE, SYNC_BYTE, 8'h00, 1'b0, '0);
    row(OP_BYTE, ADDR_BYTE, 8'h00, 1'b0, '0);
    row(OP_BYTE, 8'h7E, 8'h00, 1'b0, '0);
    row(OP_BYTE, 8'h00, 8'h00, 1'b0, '0);
    row(OP_BYTE, 8'h83, 8'h00, 1'b1, {1'b1, 1'b0, 8'h7E, 8'h00, 8'h00});
    // partial header dropped by a timeout
    row(OP_BYTE, SYNC_BYTE, 8'h00, 1'b0, '0);
    row(OP_BYTE, ADDR_BYTE, 8'h00, 1'b0, '0);
    row(OP_TIMEOUT, 8'h00, 8'h00, 1'b1, {1'b0, 1'b0, 8'h7E, 8'h00, 8'h00});
    // length above the maximum
    row(OP_BYTE, SYNC_BYTE, 8'h00, 1'b0, '0);
    row(OP_BYTE, ADDR_BYTE, 8'h00, 1'b0, '0);
    row(OP_BYTE, 8'h01, 8'h00, 1'b0, '0);
    row(OP_BYTE, 8'hFF, 8'h00, 1'b1, {1'b0, 1'b1, 8'h7E, 8'h00, 8'h00});
    // two byte frame, then reads inside and past the payload
    row(OP_BYTE, SYNC_BYTE, 8'h00, 1'b0, '0);
    row(OP_BYTE, ADDR_BYTE, 8'h00, 1'b0, '0);
    row(OP_BYTE, 8'h00, 8'h00, 1'b0, '0);
    row(OP_BYTE, 8'h02, 8'h00, 1'b0, '0);
    row(OP_BYTE, 8'hFF, 8'h00, 1'b0, '0);
    row(OP_BYTE, 8'h00, 8'h00, 1'b0, '0);
    row(OP_BYTE, 8'h00, 8'h00, 1'b1, {1'b1, 1'b0, 8'h00, 8'h02, 8'h00});
    row(OP_READ, 8'h00, 8'd0,   1'b1, {1'b0, 1'b0, 8'h00, 8'h02, 8'hFF});
    row(OP_READ, 8'h00, 8'd1,   1'b1, {1'b0, 1'b0, 8'h00, 8'h02, 8'h00});
    row(OP_READ, 8'hFF, 8'd253, 1'b1, {1'b0, 1'b0, 8'h00, 8'h02, 8'h00});

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].rx_byte, dir_rows[i].index,
                dir_rows[i].known, dir_rows[i].want);
    items_sent = 0;

    // random sequences, well-formed frames the most common kind
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if ($urandom_range(0, 3) == 0) send_item(OP_TIMEOUT, 8'h00, 8'h00, 1'b0, '0);
        if (frames_made == 2) n = MAX_LEN;
        else if ($urandom_range(0, 99) == 0) n = $urandom_range(200, MAX_LEN);
        else n = $urandom_range(0, 12);
        frames_made++;
        fill_body(n);
        emit_frame(8'($urandom_range(0, 255)), 1'b0);
        send_burst();
      end else if (pick < 55) begin
        // bad outer frame carrying a good one: both flags on replay
        fill_body($urandom_range(0, 6));
        emit_frame(8'($urandom_range(0, 255)), 1'b0);
        body_q = burst_q;
        burst_q.delete();
        repeat ($urandom_range(0, 3)) body_q.push_back(8'($urandom_range(0, 255)));
        emit_frame(8'($urandom_range(0, 255)), 1'b1);
        send_burst();
      end else if (pick < 63) begin
        fill_body($urandom_range(0, 12));
        emit_frame(8'($urandom_range(0, 255)), 1'b1);
        send_burst();
      end else if (pick < 68) begin
        // length field over the limit
        burst_q.push_back(SYNC_BYTE);
        burst_q.push_back(ADDR_BYTE);
        burst_q.push_back(8'($urandom_range(0, 255)));
        burst_q.push_back(8'hFF);
        repeat ($urandom_range(0, 3)) burst_q.push_back(rand_byte());
        send_burst();
      end else if (pick < 73) begin
        // broken preamble
        burst_q.push_back($urandom_range(0, 1) ? SYNC_BYTE : rand_byte());
        burst_q.push_back(8'($urandom_range(0, 254)));
        burst_q.push_back(rand_byte());
        burst_q.push_back(rand_byte());
        send_burst();
      end else if (pick < 80) begin
        // truncated frame, then timeout
        fill_body($urandom_range(0, 12));
        emit_frame(8'($urandom_range(0, 255)), 1'b0);
        n = $urandom_range(1, burst_q.size() - 1);
        while (burst_q.size() > n) void'(burst_q.pop_back());
        send_burst();
        send_item(OP_TIMEOUT, 8'($urandom_range(0, 255)), 8'h00, 1'b0, '0);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 8)) burst_q.push_back(rand_byte());
        send_burst();
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 4)) begin
          if (good_len != 0 && $urandom_range(0, 1) == 0) k = $urandom_range(0, good_len - 1);
          else k = $urandom_range(0, 253);
          send_item(OP_READ, 8'($urandom_range(0, 255)), 8'(k), 1'b0, '0);
        end
      end else begin
        send_item($urandom_range(0, 1) ? OP_NOP : OP_TIMEOUT, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;

    // drain
    while (status_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) $display("serial_frame_deframer_core_tb: PASS");
    else $display("serial_frame_deframer_core_tb: FAIL");
    $finish;
  end

endmodule
